// ----- sv/dlrl_pkg.sv -----
// dlrl_pkg: shared types and constants for the diagonal line run length unit.
// Used by dlrl_alu, diagonal_line_run_lengths_unit and dlrl_checker.
`timescale 1ns / 1ps

package dlrl_pkg;

    // Width of every length field on the ports
    localparam int FIELD_W     = 7;
    // Default upper bound on a side length
    localparam int DEF_MAX_LEN = 64;

    // One line request
    typedef struct packed {
        logic [FIELD_W-1:0] length_x;
        logic [FIELD_W-1:0] length_y;
    } line_t;

    // One run result
    typedef struct packed {
        logic [FIELD_W-1:0] repeat_count;
        logic [FIELD_W-1:0] run_length;
        logic               last_run;
        logic               zero_error;
    } run_t;

    // Compare flags from the shared subtractor
    typedef struct packed {
        logic ge;    // a >= b
        logic eq;    // a == b
    } alu_flags_t;

endpackage

// ----- sv/dlrl_alu.sv -----
// dlrl_alu: shared subtract and compare unit, reused by every step of the sequencer.
// Depends on dlrl_pkg for the flag struct.
`timescale 1ns / 1ps

module dlrl_alu
    import dlrl_pkg::*;
#(
    parameter int W = 7
)
(
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic [W-1:0] diff,
    output alu_flags_t   flags
);

    logic [W:0] wide_diff;

    // One subtract with borrow gives both the difference and the order
    always_comb
    begin
        wide_diff = {1'b0, a} - {1'b0, b};
        diff      = wide_diff[W-1:0];
        flags.ge  = ~wide_diff[W];
        flags.eq  = (wide_diff == '0);
    end

endmodule

// ----- sv/diagonal_line_run_lengths_unit.sv -----
// diagonal_line_run_lengths_unit: top level, sequencer around one shared subtractor.
// Depends on dlrl_pkg and dlrl_alu.
`timescale 1ns / 1ps
//
// Usage
//   Line channel: line_valid / line_stall / line_data (length_x, length_y).
//   Run channel:  run_valid / run_stall / run_data (repeat_count, run_length,
//   last_run, zero_error). An item moves when valid is high and stall is low.
//   A zero side gives one item with zero_error set and last_run set. Otherwise
//   lengths are clamped to MAX_LEN, ordered, reduced by their gcd g, and one
//   item per row of the reduced pattern follows, the final one with last_run.
//   Timing: the gcd, the reductions and the row walk all use a single
//   subtract/compare unit, one step per cycle unless the walk waits on the
//   output register: the gcd (subtract and swap), then the two reductions s/g
//   and l/g, then one step that sets up the row walk, then the walk, one column
//   per step. A zero side goes straight to its error item.
//   line_stall is high from the cycle after acceptance until the last run item
//   is loaded into the output register; the next line may enter while that
//   item still waits there.
//   A stalled run item holds; the walk pauses until the output register frees.
//   Reset clears the sequencer and drops run_valid; no item is in flight.
//
module diagonal_line_run_lengths_unit
    import dlrl_pkg::*;
#(
    parameter int MAX_LEN = DEF_MAX_LEN
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  line_valid,
    output logic  line_stall,
    input  line_t line_data,
    output logic  run_valid,
    input  logic  run_stall,
    output run_t  run_data
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_GCD,
        ST_DIV_S,
        ST_DIV_L,
        ST_GAP,
        ST_RUN
    } state_t;

    state_t           state_reg,  state_next;
    logic [LEN_W-1:0] s_reg,      s_next;      // short side
    logic [LEN_W-1:0] l_reg,      l_next;      // long side
    logic [LEN_W-1:0] ga_reg,     ga_next;     // gcd operand, holds g afterwards
    logic [LEN_W-1:0] gb_reg,     gb_next;     // gcd operand, then work / accumulator
    logic [LEN_W-1:0] q_reg,      q_next;      // quotient, then run counter
    logic [LEN_W-1:0] sp_reg,     sp_next;     // s / g
    logic [LEN_W-1:0] lp_reg,     lp_next;     // l / g
    logic [LEN_W-1:0] gap_reg,    gap_next;    // l' - s'
    logic [LEN_W-1:0] row_reg,    row_next;
    logic             run_valid_reg, run_valid_next;
    run_t             run_data_reg,  run_data_next;

    logic [LEN_W-1:0] alu_a, alu_b, alu_diff;
    alu_flags_t       alu_flags;
    logic [LEN_W-1:0] x_len, y_len;
    logic             out_free;
    logic             is_last;

    // Clamp incoming lengths to the bound
    always_comb
    begin
        if (line_data.length_x > FIELD_W'(MAX_LEN))
            x_len = LEN_W'(MAX_LEN);
        else
            x_len = line_data.length_x[LEN_W-1:0];
        if (line_data.length_y > FIELD_W'(MAX_LEN))
            y_len = LEN_W'(MAX_LEN);
        else
            y_len = line_data.length_y[LEN_W-1:0];
    end

    // Operand select for the shared unit
    always_comb
    begin
        case (state_reg)
            ST_GCD:
            begin
                alu_a = ga_reg;
                alu_b = gb_reg;
            end
            ST_DIV_S, ST_DIV_L:
            begin
                alu_a = gb_reg;
                alu_b = ga_reg;
            end
            ST_GAP:
            begin
                alu_a = lp_reg;
                alu_b = sp_reg;
            end
            ST_RUN:
            begin
                alu_a = gb_reg;
                alu_b = gap_reg;
            end
            default:
            begin
                alu_a = ga_reg;
                alu_b = gb_reg;
            end
        endcase
    end

    dlrl_alu #(
        .W (LEN_W)
    ) u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .diff  (alu_diff),
        .flags (alu_flags)
    );

    assign out_free = ~run_valid_reg | ~run_stall;
    assign is_last  = (LEN_W'(row_reg + 1'b1) == sp_reg);

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        s_next         = s_reg;
        l_next         = l_reg;
        ga_next        = ga_reg;
        gb_next        = gb_reg;
        q_next         = q_reg;
        sp_next        = sp_reg;
        lp_next        = lp_reg;
        gap_next       = gap_reg;
        row_next       = row_reg;
        run_data_next  = run_data_reg;
        run_valid_next = run_valid_reg & run_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (line_valid)
                begin
                    if (x_len == '0 || y_len == '0)
                    begin
                        state_next = ST_ERR;
                    end
                    else
                    begin
                        s_next     = (x_len < y_len) ? x_len : y_len;
                        l_next     = (x_len < y_len) ? y_len : x_len;
                        ga_next    = (x_len < y_len) ? y_len : x_len;
                        gb_next    = (x_len < y_len) ? x_len : y_len;
                        state_next = ST_GCD;
                    end
                end
            end
            ST_ERR:
            begin
                if (out_free)
                begin
                    run_valid_next              = 1'b1;
                    run_data_next.repeat_count = '0;
                    run_data_next.run_length   = '0;
                    run_data_next.last_run     = 1'b1;
                    run_data_next.zero_error   = 1'b1;
                    state_next                  = ST_IDLE;
                end
            end
            // Subtractive gcd, swapping to keep the larger operand in ga
            ST_GCD:
            begin
                if (alu_flags.eq)
                begin
                    gb_next    = s_reg;
                    q_next     = '0;
                    state_next = ST_DIV_S;
                end
                else if (alu_flags.ge)
                begin
                    ga_next = alu_diff;
                end
                else
                begin
                    ga_next = gb_reg;
                    gb_next = ga_reg;
                end
            end
            // Exact division by repeated subtraction of g
            ST_DIV_S:
            begin
                if (alu_flags.eq)
                begin
                    sp_next    = LEN_W'(q_reg + 1'b1);
                    gb_next    = l_reg;
                    q_next     = '0;
                    state_next = ST_DIV_L;
                end
                else
                begin
                    gb_next = alu_diff;
                    q_next  = LEN_W'(q_reg + 1'b1);
                end
            end
            ST_DIV_L:
            begin
                if (alu_flags.eq)
                begin
                    lp_next    = LEN_W'(q_reg + 1'b1);
                    state_next = ST_GAP;
                end
                else
                begin
                    gb_next = alu_diff;
                    q_next  = LEN_W'(q_reg + 1'b1);
                end
            end
            ST_GAP:
            begin
                gap_next   = alu_diff;
                gb_next    = '0;
                q_next     = '0;
                row_next   = '0;
                state_next = ST_RUN;
            end
            // One column per cycle while out_free; a row closes when acc + s' reaches l'
            ST_RUN:
            begin
                if (out_free)
                begin
                    if (alu_flags.ge)
                    begin
                        run_valid_next              = 1'b1;
                        run_data_next.repeat_count = FIELD_W'(ga_reg);
                        run_data_next.run_length   = FIELD_W'(LEN_W'(q_reg + 1'b1));
                        run_data_next.last_run     = is_last;
                        run_data_next.zero_error   = 1'b0;
                        gb_next                     = alu_diff;
                        q_next                      = '0;
                        row_next                    = LEN_W'(row_reg + 1'b1);
                        if (is_last)
                            state_next = ST_IDLE;
                    end
                    else
                    begin
                        gb_next = LEN_W'(gb_reg + sp_reg);
                        q_next  = LEN_W'(q_reg + 1'b1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            s_reg         <= '0;
            l_reg         <= '0;
            ga_reg        <= '0;
            gb_reg        <= '0;
            q_reg         <= '0;
            sp_reg        <= '0;
            lp_reg        <= '0;
            gap_reg       <= '0;
            row_reg       <= '0;
            run_valid_reg <= 1'b0;
            run_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            s_reg         <= s_next;
            l_reg         <= l_next;
            ga_reg        <= ga_next;
            gb_reg        <= gb_next;
            q_reg         <= q_next;
            sp_reg        <= sp_next;
            lp_reg        <= lp_next;
            gap_reg       <= gap_next;
            row_reg       <= row_next;
            run_valid_reg <= run_valid_next;
            run_data_reg  <= run_data_next;
        end
    end

    assign line_stall = (state_reg != ST_IDLE);
    assign run_valid  = run_valid_reg;
    assign run_data   = run_data_reg;

endmodule

// ----- sv/dlrl_checker.sv -----
// dlrl_checker: port-level assertions for diagonal_line_run_lengths_unit, bound in below.
// Depends on dlrl_pkg for the channel types.
`timescale 1ns / 1ps

module dlrl_checker
    import dlrl_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  line_valid,
    input logic  line_stall,
    input line_t line_data,
    input logic  run_valid,
    input logic  run_stall,
    input run_t  run_data
);

    // An error item is always a lone, empty, final item
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid && run_data.zero_error |->
            run_data.last_run && run_data.run_length == '0 &&
            run_data.repeat_count == '0)
        else $error("error item with bad fields");

    // A normal run is never empty and always carries a nonzero repeat count
    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid && !run_data.zero_error |->
            run_data.run_length != '0 && run_data.repeat_count != '0)
        else $error("empty run or zero repeat count");

    // An accepted line keeps the input closed on the following cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        line_valid && !line_stall |=> line_stall)
        else $error("line taken while still busy");

    // A stalled run item holds
    a_run_hold: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid && run_stall |=> run_valid && $stable(run_data))
        else $error("stalled run item changed");

endmodule

bind diagonal_line_run_lengths_unit dlrl_checker u_dlrl_checker (.*);
